### src/i2cbm_pkg.sv
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared types and constants of the I2C bit-level master: command codes,
// item classes and the word passed from the front end to the bit engine.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

  // Raw kind codes on the input channel.
  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_START   = 3'd1;
  localparam logic [2:0] KIND_WRITE   = 3'd3;
  localparam logic [2:0] KIND_READ    = 3'd4;
  localparam logic [2:0] KIND_ACK     = 3'd5;
  localparam logic [2:0] KIND_WAITACK = 3'd6;

  // Bus command held by the engine while a sequence runs.
  typedef enum logic [2:0] {
    CMD_IDLE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_WRITE   = 3'd3,
    CMD_READ    = 3'd4,
    CMD_ACK     = 3'd5,
    CMD_WAITACK = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ITEM_TICK = 2'd0,
    ITEM_CMD  = 2'd1,
    ITEM_NOP  = 2'd2
  } item_kind_t;

  // Classified word waiting in the queue.
  typedef struct packed {
    item_kind_t  kind;
    cmd_t        cmd;
    logic        load_shift;
    logic [7:0]  shift_val;
    logic        sda;
  } item_t;

  // Result word held in the output register.
  typedef struct packed {
    logic        scl_level;
    logic        sda_level;
    logic        busy_res;
    logic        done_res;
    logic        rejected;
    logic [7:0]  read_data;
    logic        nack;
  } result_t;

  localparam int unsigned QUEUE_DEPTH_DEF   = 4;
  localparam int unsigned CFG_ADDR_W        = 3;
  localparam logic        REG_HALF_PERIOD   = 1'b0;
  localparam logic [15:0] HALF_PERIOD_RESET = 16'd5;
  localparam logic [4:0]  LAST_BYTE_SEG     = 5'd17;

endpackage

### src/i2c_bit_level_master.sv
// ----------------------------------------------------------------------------
// i2c_bit_level_master
// Open-drain I2C master bit engine with an APB-style register for the delay.
// ----------------------------------------------------------------------------
// Every input word (a tick carrying the sampled SDA level, a start, stop,
// write byte, read byte, send ack or wait ack command, or an unused kind)
// returns exactly one result word with the SCL/SDA drive levels and status
// after that word. The block takes one word per clock while the input queue
// is not full and the output register is not stalled; a result passes
// through the input queue and then the output register. Each protocol delay
// lasts half_period ticks (zero acts as one); half_period sits at byte
// address 0 and should be written only while no command is running.
module i2c_bit_level_master #(
  parameter int unsigned QUEUE_DEPTH = i2cbm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        in_kind,
  input  logic [7:0]                        in_byte_value,
  input  logic                              in_ack_level,
  input  logic                              in_sda_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_scl_level,
  output logic                              out_sda_level,
  output logic                              out_busy_res,
  output logic                              out_done_res,
  output logic                              out_rejected,
  output logic [7:0]                        out_read_data,
  output logic                              out_nack,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [i2cbm_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [15:0]        half_period_r;
  logic               reg_sel;
  logic               head_valid;
  i2cbm_pkg::item_t   head;
  logic               pop;
  i2cbm_pkg::result_t result;

  // The register index is the word address.
  assign reg_sel = (paddr[i2cbm_pkg::CFG_ADDR_W-1] == i2cbm_pkg::REG_HALF_PERIOD);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {16'd0, half_period_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= i2cbm_pkg::HALF_PERIOD_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      half_period_r <= pwdata[15:0];
    end
  end

  i2cbm_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_byte_value (in_byte_value),
    .in_ack_level  (in_ack_level),
    .in_sda_sample (in_sda_sample),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop)
  );

  i2cbm_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .half_period (half_period_r),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result      (result)
  );

  assign out_scl_level = result.scl_level;
  assign out_sda_level = result.sda_level;
  assign out_busy_res  = result.busy_res;
  assign out_done_res  = result.done_res;
  assign out_rejected  = result.rejected;
  assign out_read_data = result.read_data;
  assign out_nack      = result.nack;

endmodule

### src/i2cbm_front.sv
// ----------------------------------------------------------------------------
// i2cbm_front
// Accepts input words, sorts them into ticks, commands and no-ops, prepares
// the shift value of a command and keeps them in a short queue.
// ----------------------------------------------------------------------------
module i2cbm_front #(
  parameter int unsigned QUEUE_DEPTH = i2cbm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_kind,
  input  logic [7:0]        in_byte_value,
  input  logic              in_ack_level,
  input  logic              in_sda_sample,
  output logic              head_valid,
  output i2cbm_pkg::item_t  head,
  input  logic              pop
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  i2cbm_pkg::item_t q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  i2cbm_pkg::item_t cls;
  logic             push;

  always_comb begin
    cls            = '0;
    cls.kind       = i2cbm_pkg::ITEM_NOP;
    cls.cmd        = i2cbm_pkg::CMD_IDLE;
    cls.sda        = in_sda_sample;
    if (in_kind == i2cbm_pkg::KIND_TICK) begin
      cls.kind = i2cbm_pkg::ITEM_TICK;
    end else if (in_kind inside {[i2cbm_pkg::KIND_START:i2cbm_pkg::KIND_WAITACK]}) begin
      cls.kind = i2cbm_pkg::ITEM_CMD;
      cls.cmd  = i2cbm_pkg::cmd_t'(in_kind);
    end
    case (in_kind)
      i2cbm_pkg::KIND_WRITE: begin
        cls.load_shift = 1'b1;
        cls.shift_val  = in_byte_value;
      end
      i2cbm_pkg::KIND_ACK: begin
        cls.load_shift = 1'b1;
        cls.shift_val  = {7'd0, in_ack_level};
      end
      i2cbm_pkg::KIND_READ: begin
        cls.load_shift = 1'b1;
        cls.shift_val  = 8'd0;
      end
      default: begin
        cls.load_shift = 1'b0;
      end
    endcase
  end

  assign in_stall   = (count_r == CNT_W'(QUEUE_DEPTH));
  assign push       = in_valid && !in_stall;
  assign head_valid = (count_r != '0);
  assign head       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

### src/i2cbm_engine.sv
// ----------------------------------------------------------------------------
// i2cbm_engine
// Bit engine: takes one queued word per cycle unless the output stalls, steps
// the SCL/SDA sequence of the running command and registers the result word.
// ----------------------------------------------------------------------------
module i2cbm_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [15:0]         half_period,
  input  logic                head_valid,
  input  i2cbm_pkg::item_t    head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output i2cbm_pkg::result_t  result
);

  i2cbm_pkg::cmd_t    cmd_r, cmd_nxt;
  logic [4:0]         step_r, step_nxt;
  logic [15:0]        timer_r, timer_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic               scl_r, scl_nxt;
  logic               sda_r, sda_nxt;
  logic               nack_r, nack_nxt;
  logic [7:0]         read_r, read_nxt;
  logic               out_valid_r;
  i2cbm_pkg::result_t out_r;

  logic               fire;
  logic               busy;
  logic [15:0]        delay;
  logic [15:0]        timer_dec;
  logic               done;
  logic               rej;

  // Segment evaluation, shared by a new command (segment 0) and by a tick
  // that ends a delay (next segment of the running command).
  i2cbm_pkg::cmd_t    seg_cmd;
  logic [4:0]         seg_s;
  logic [7:0]         seg_shift_in;
  logic               seg_scl, seg_sda, seg_nack, seg_more;
  logic [7:0]         seg_shift, seg_read;

  assign fire      = head_valid && (!out_valid_r || !out_stall);
  assign pop       = fire;
  assign busy      = (cmd_r != i2cbm_pkg::CMD_IDLE);
  assign delay     = (half_period == 16'd0) ? 16'd1 : half_period;
  assign timer_dec = timer_r - 16'd1;

  always_comb begin
    if (head.kind == i2cbm_pkg::ITEM_CMD) begin
      seg_cmd      = head.cmd;
      seg_s        = 5'd0;
      seg_shift_in = head.load_shift ? head.shift_val : shift_r;
    end else begin
      seg_cmd      = cmd_r;
      seg_s        = step_r + 5'd1;
      seg_shift_in = shift_r;
    end
  end

  always_comb begin
    seg_scl   = scl_r;
    seg_sda   = sda_r;
    seg_nack  = nack_r;
    seg_read  = read_r;
    seg_shift = seg_shift_in;
    seg_more  = 1'b1;
    case (seg_cmd)
      i2cbm_pkg::CMD_START: begin
        if (seg_s == 5'd0) begin
          seg_sda = 1'b1;
          seg_scl = 1'b1;
        end else if (seg_s == 5'd1) begin
          seg_sda = 1'b0;
        end else begin
          seg_scl  = 1'b0;
          seg_more = 1'b0;
        end
      end
      i2cbm_pkg::CMD_STOP: begin
        if (seg_s == 5'd0) begin
          seg_sda = 1'b0;
          seg_scl = 1'b0;
        end else if (seg_s == 5'd1) begin
          seg_scl = 1'b1;
        end else begin
          seg_sda  = 1'b1;
          seg_more = 1'b0;
        end
      end
      i2cbm_pkg::CMD_WRITE: begin
        if (seg_s == 5'd0) begin
          seg_scl = 1'b0;
        end else if (seg_s >= i2cbm_pkg::LAST_BYTE_SEG) begin
          seg_more = 1'b0;
        end else if (seg_s[0]) begin
          seg_sda   = seg_shift_in[7];
          seg_shift = {seg_shift_in[6:0], 1'b0};
          seg_scl   = 1'b1;
        end else begin
          seg_scl = 1'b0;
        end
      end
      i2cbm_pkg::CMD_READ: begin
        if (seg_s == 5'd0) begin
          seg_sda = 1'b1;
          seg_scl = 1'b0;
        end else if (seg_s >= i2cbm_pkg::LAST_BYTE_SEG) begin
          seg_read = seg_shift_in;
          seg_more = 1'b0;
        end else if (seg_s[0]) begin
          seg_scl = 1'b1;
        end else begin
          seg_shift = {seg_shift_in[6:0], head.sda};
          seg_scl   = 1'b0;
        end
      end
      i2cbm_pkg::CMD_ACK: begin
        if (seg_s == 5'd0) begin
          seg_scl = 1'b0;
        end else if (seg_s == 5'd1) begin
          seg_sda = seg_shift_in[0];
          seg_scl = 1'b1;
        end else begin
          seg_scl  = 1'b0;
          seg_more = 1'b0;
        end
      end
      i2cbm_pkg::CMD_WAITACK: begin
        if (seg_s == 5'd0) begin
          seg_sda = 1'b1;
          seg_scl = 1'b0;
        end else if (seg_s == 5'd1) begin
          seg_scl = 1'b1;
        end else begin
          seg_nack = head.sda;
          seg_scl  = 1'b0;
          seg_more = 1'b0;
        end
      end
      default: begin
        seg_more = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd_nxt   = cmd_r;
    step_nxt  = step_r;
    timer_nxt = timer_r;
    shift_nxt = shift_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    nack_nxt  = nack_r;
    read_nxt  = read_r;
    done      = 1'b0;
    rej       = 1'b0;
    if (fire) begin
      case (head.kind)
        i2cbm_pkg::ITEM_TICK: begin
          if (busy) begin
            timer_nxt = timer_dec;
            if (timer_dec == 16'd0) begin
              shift_nxt = seg_shift;
              scl_nxt   = seg_scl;
              sda_nxt   = seg_sda;
              nack_nxt  = seg_nack;
              read_nxt  = seg_read;
              if (seg_more) begin
                step_nxt  = seg_s;
                timer_nxt = delay;
              end else begin
                cmd_nxt   = i2cbm_pkg::CMD_IDLE;
                step_nxt  = 5'd0;
                timer_nxt = 16'd0;
                done      = 1'b1;
              end
            end
          end
        end
        i2cbm_pkg::ITEM_CMD: begin
          if (busy) begin
            rej = 1'b1;
          end else begin
            cmd_nxt   = head.cmd;
            step_nxt  = 5'd0;
            timer_nxt = delay;
            shift_nxt = seg_shift;
            scl_nxt   = seg_scl;
            sda_nxt   = seg_sda;
            nack_nxt  = seg_nack;
            read_nxt  = seg_read;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r       <= i2cbm_pkg::CMD_IDLE;
      step_r      <= 5'd0;
      timer_r     <= 16'd0;
      shift_r     <= 8'd0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      nack_r      <= 1'b0;
      read_r      <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      cmd_r   <= cmd_nxt;
      step_r  <= step_nxt;
      timer_r <= timer_nxt;
      shift_r <= shift_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      nack_r  <= nack_nxt;
      read_r  <= read_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r.scl_level <= scl_nxt;
      out_r.sda_level <= sda_nxt;
      out_r.busy_res  <= (cmd_nxt != i2cbm_pkg::CMD_IDLE);
      out_r.done_res  <= done;
      out_r.rejected  <= rej;
      out_r.read_data <= read_nxt;
      out_r.nack      <= nack_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = out_r;

  // A running command always has a delay pending.
  a_timer_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (timer_r != 16'd0))
    else $error("engine busy with an expired delay timer");

  // No sequence goes past the last bit of a byte transfer.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= i2cbm_pkg::LAST_BYTE_SEG)
    else $error("step index beyond the last byte segment");

  // A finished command leaves the engine idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.done_res) |-> !out_r.busy_res)
    else $error("done reported while still busy");

  // A rejected command can only have met a running one.
  a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.rejected) |-> out_r.busy_res)
    else $error("command rejected while idle");

endmodule

### tb/i2cbm_checker.sv
// ----------------------------------------------------------------------------
// i2cbm_checker
// Watches the input, result and register ports of the I2C bit-level master,
// predicts the drive levels and status for every accepted word and compares
// each result word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module i2cbm_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [2:0]                        in_kind,
  input  logic [7:0]                        in_byte_value,
  input  logic                              in_ack_level,
  input  logic                              in_sda_sample,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic                              out_scl_level,
  input  logic                              out_sda_level,
  input  logic                              out_busy_res,
  input  logic                              out_done_res,
  input  logic                              out_rejected,
  input  logic [7:0]                        out_read_data,
  input  logic                              out_nack,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [i2cbm_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                       pwdata,
  input  logic                              pready,
  output int                                errors,
  output int                                pending
);

  localparam int unsigned ADDR_W = i2cbm_pkg::CFG_ADDR_W;
  localparam logic [ADDR_W-1:0] HALF_PERIOD_ADDR =
    ADDR_W'({i2cbm_pkg::REG_HALF_PERIOD, 2'b00});

  // Mirror of the engine state.
  logic [15:0]          period_q;
  i2cbm_pkg::cmd_t      seq_cmd;
  logic [4:0]           seg_idx;
  logic [15:0]          delay_cnt;
  logic [7:0]           shreg;
  logic                 scl_q;
  logic                 sda_q;
  logic                 nack_q;
  logic [7:0]           rd_q;

  i2cbm_pkg::result_t   pin_status_q[$];
  i2cbm_pkg::result_t   want;

  task automatic report(input string msg);
    errors = errors + 1;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int exp_val);
    if (got != exp_val) begin
      report($sformatf("%s is %0h, predicted %0h", name, got, exp_val));
    end
  endtask

  // Pin actions of one segment of the running command; returns 1 when a
  // delay follows, 0 when the command is complete.
  function automatic logic run_segment(input logic [4:0] s, input logic sda_in);
    logic more;
    more = 1'b1;
    case (seq_cmd)
      i2cbm_pkg::CMD_START: begin
        if (s == 5'd0) begin
          sda_q = 1'b1;
          scl_q = 1'b1;
        end else if (s == 5'd1) begin
          sda_q = 1'b0;
        end else begin
          scl_q = 1'b0;
          more  = 1'b0;
        end
      end
      i2cbm_pkg::CMD_STOP: begin
        if (s == 5'd0) begin
          sda_q = 1'b0;
          scl_q = 1'b0;
        end else if (s == 5'd1) begin
          scl_q = 1'b1;
        end else begin
          sda_q = 1'b1;
          more  = 1'b0;
        end
      end
      i2cbm_pkg::CMD_WRITE: begin
        if (s == 5'd0) begin
          scl_q = 1'b0;
        end else if (s >= i2cbm_pkg::LAST_BYTE_SEG) begin
          more = 1'b0;
        end else if (s[0]) begin
          sda_q = shreg[7];
          shreg = {shreg[6:0], 1'b0};
          scl_q = 1'b1;
        end else begin
          scl_q = 1'b0;
        end
      end
      i2cbm_pkg::CMD_READ: begin
        if (s == 5'd0) begin
          sda_q = 1'b1;
          scl_q = 1'b0;
        end else if (s >= i2cbm_pkg::LAST_BYTE_SEG) begin
          rd_q = shreg;
          more = 1'b0;
        end else if (s[0]) begin
          scl_q = 1'b1;
        end else begin
          shreg = {shreg[6:0], sda_in};
          scl_q = 1'b0;
        end
      end
      i2cbm_pkg::CMD_ACK: begin
        if (s == 5'd0) begin
          scl_q = 1'b0;
        end else if (s == 5'd1) begin
          sda_q = shreg[0];
          scl_q = 1'b1;
        end else begin
          scl_q = 1'b0;
          more  = 1'b0;
        end
      end
      i2cbm_pkg::CMD_WAITACK: begin
        if (s == 5'd0) begin
          sda_q = 1'b1;
          scl_q = 1'b0;
        end else if (s == 5'd1) begin
          scl_q = 1'b1;
        end else begin
          nack_q = sda_in;
          scl_q  = 1'b0;
          more   = 1'b0;
        end
      end
      default: more = 1'b0;
    endcase
    return more;
  endfunction

  function automatic i2cbm_pkg::result_t step_engine(input logic [2:0] kind,
                                                     input logic [7:0] byte_val,
                                                     input logic ack, input logic sda);
    i2cbm_pkg::result_t r;
    logic               fin;
    logic               rej;
    logic [15:0]        dly;
    fin = 1'b0;
    rej = 1'b0;
    // A period of zero behaves as one tick.
    dly = (period_q == 16'd0) ? 16'd1 : period_q;
    if (kind == i2cbm_pkg::KIND_TICK) begin
      if (seq_cmd != i2cbm_pkg::CMD_IDLE) begin
        delay_cnt = delay_cnt - 16'd1;
        if (delay_cnt == 16'd0) begin
          seg_idx = seg_idx + 5'd1;
          if (run_segment(seg_idx, sda)) begin
            delay_cnt = dly;
          end else begin
            seq_cmd   = i2cbm_pkg::CMD_IDLE;
            seg_idx   = 5'd0;
            delay_cnt = 16'd0;
            fin       = 1'b1;
          end
        end
      end
    end else if (kind <= i2cbm_pkg::CMD_WAITACK) begin
      if (seq_cmd != i2cbm_pkg::CMD_IDLE) begin
        rej = 1'b1;
      end else begin
        seq_cmd = i2cbm_pkg::cmd_t'(kind);
        seg_idx = 5'd0;
        case (seq_cmd)
          i2cbm_pkg::CMD_WRITE: shreg = byte_val;
          i2cbm_pkg::CMD_ACK:   shreg = {7'd0, ack};
          i2cbm_pkg::CMD_READ:  shreg = 8'd0;
          default: ;
        endcase
        void'(run_segment(5'd0, 1'b0));
        delay_cnt = dly;
      end
    end
    r.scl_level = scl_q;
    r.sda_level = sda_q;
    r.busy_res  = (seq_cmd != i2cbm_pkg::CMD_IDLE);
    r.done_res  = fin;
    r.rejected  = rej;
    r.read_data = rd_q;
    r.nack      = nack_q;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      period_q  = i2cbm_pkg::HALF_PERIOD_RESET;
      seq_cmd   = i2cbm_pkg::CMD_IDLE;
      seg_idx   = 5'd0;
      delay_cnt = 16'd0;
      shreg     = 8'd0;
      scl_q     = 1'b1;
      sda_q     = 1'b1;
      nack_q    = 1'b0;
      rd_q      = 8'd0;
      errors    = 0;
      pin_status_q.delete();
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == HALF_PERIOD_ADDR) begin
        period_q = pwdata[15:0];
      end
      if (in_valid && !in_stall) begin
        pin_status_q.push_back(step_engine(in_kind, in_byte_value, in_ack_level,
                                           in_sda_sample));
      end
      if (out_valid && !out_stall) begin
        if (pin_status_q.size() == 0) begin
          report("result word arrived with no prediction waiting");
        end else begin
          want = pin_status_q.pop_front();
          check_field("scl_level", int'(out_scl_level), int'(want.scl_level));
          check_field("sda_level", int'(out_sda_level), int'(want.sda_level));
          check_field("busy_res", int'(out_busy_res), int'(want.busy_res));
          check_field("done_res", int'(out_done_res), int'(want.done_res));
          check_field("rejected", int'(out_rejected), int'(want.rejected));
          check_field("read_data", int'(out_read_data), int'(want.read_data));
          check_field("nack", int'(out_nack), int'(want.nack));
        end
      end
      pending <= pin_status_q.size();
    end
  end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the I2C bit-level master with directed and random command and tick
// words, random valid gaps and result stalls, and half-period settings from
// zero up to a long delay; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned ADDR_W = i2cbm_pkg::CFG_ADDR_W;
  localparam logic [2:0] KIND_UNUSED  = 3'd7;
  localparam logic [ADDR_W-1:0] HALF_PERIOD_ADDR =
    ADDR_W'({i2cbm_pkg::REG_HALF_PERIOD, 2'b00});
  localparam int LIMIT_CYCLES = 4000000;
  localparam int RANDOM_WORDS = 1200;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [2:0]        in_kind;
  logic [7:0]        in_byte_value;
  logic              in_ack_level;
  logic              in_sda_sample;
  logic              out_valid;
  logic              out_stall;
  logic              out_scl_level;
  logic              out_sda_level;
  logic              out_busy_res;
  logic              out_done_res;
  logic              out_rejected;
  logic [7:0]        out_read_data;
  logic              out_nack;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int                errors;
  int                pending;
  int                cycle_cnt = 0;
  int                words_sent;
  int                period_eff;
  bit                tx_gaps;
  bit                rx_gaps;
  bit                hold_request;
  bit                hold_done;

  i2c_bit_level_master i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_byte_value (in_byte_value),
    .in_ack_level  (in_ack_level),
    .in_sda_sample (in_sda_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_scl_level (out_scl_level),
    .out_sda_level (out_sda_level),
    .out_busy_res  (out_busy_res),
    .out_done_res  (out_done_res),
    .out_rejected  (out_rejected),
    .out_read_data (out_read_data),
    .out_nack      (out_nack),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  i2cbm_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_byte_value (in_byte_value),
    .in_ack_level  (in_ack_level),
    .in_sda_sample (in_sda_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_scl_level (out_scl_level),
    .out_sda_level (out_sda_level),
    .out_busy_res  (out_busy_res),
    .out_done_res  (out_done_res),
    .out_rejected  (out_rejected),
    .out_read_data (out_read_data),
    .out_nack      (out_nack),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .errors        (errors),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("** i2c_bit_level_master: FAILED **");
      $finish;
    end
  end

  // Result side: short random stalls, or one long hold-off on request.
  initial begin
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (80) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Called at a rising edge; returns at the edge where the word is taken,
  // with valid still high.
  task automatic push_word(input logic [2:0] k, input logic [7:0] b, input logic a,
                           input logic s);
    bit taken;
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= k;
    in_byte_value <= b;
    in_ack_level  <= a;
    in_sda_sample <= s;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  // Stop offering words and wait until every predicted result has come back.
  task automatic drain;
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending != 0);
    @(posedge clk);
  endtask

  task automatic cfg_write(input logic [15:0] v);
    bit ready;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= HALF_PERIOD_ADDR;
    pwdata  <= {16'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ready = pready;
      @(posedge clk);
    end while (!ready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    period_eff = (v == 16'd0) ? 1 : int'(v);
  endtask

  // One command followed by exactly the ticks it needs to finish. With
  // noise, stray commands (rejected while busy) and unused kinds are mixed
  // in between the ticks.
  task automatic run_cmd(input logic [2:0] k, input logic [7:0] b, input logic a,
                         input bit noisy);
    int n;
    int i;
    n = ((k == i2cbm_pkg::KIND_WRITE || k == i2cbm_pkg::KIND_READ) ?
         int'(i2cbm_pkg::LAST_BYTE_SEG) : 2) * period_eff;
    push_word(k, b, a, 1'($urandom_range(0, 1)));
    words_sent++;
    for (i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) begin
        push_word(3'($urandom_range(1, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end
      push_word(i2cbm_pkg::KIND_TICK, 8'($urandom), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
      words_sent++;
    end
  endtask

  initial begin
    int nb;
    int i;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_kind       <= i2cbm_pkg::KIND_TICK;
    in_byte_value <= 8'd0;
    in_ack_level  <= 1'b0;
    in_sda_sample <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= 32'd0;
    hold_request  = 1'b0;
    tx_gaps       = 1'b1;
    rx_gaps       = 1'b1;
    words_sent    = 0;
    period_eff    = int'(i2cbm_pkg::HALF_PERIOD_RESET);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle ticks and the unused kind change nothing; a start runs
    // with the reset period and a command sent while busy is rejected.
    push_word(i2cbm_pkg::KIND_TICK, 8'h00, 1'b0, 1'b1);
    push_word(i2cbm_pkg::KIND_TICK, 8'hFF, 1'b1, 1'b0);
    push_word(KIND_UNUSED, 8'hFF, 1'b1, 1'b1);
    push_word(i2cbm_pkg::KIND_START, 8'h00, 1'b0, 1'b0);
    push_word(i2cbm_pkg::KIND_WRITE, 8'hFF, 1'b1, 1'b1);
    for (i = 0; i < 2 * period_eff; i++) begin
      push_word(i2cbm_pkg::KIND_TICK, 8'h00, 1'b0, 1'b0);
    end
    drain();

    // A period of zero behaves as one.
    cfg_write(16'd0);
    run_cmd(i2cbm_pkg::KIND_WRITE, 8'hFF, 1'b0, 1'b0);
    run_cmd(i2cbm_pkg::KIND_WAITACK, 8'h00, 1'b0, 1'b0);
    run_cmd(i2cbm_pkg::KIND_WRITE, 8'h00, 1'b1, 1'b0);
    run_cmd(i2cbm_pkg::KIND_READ, 8'hFF, 1'b0, 1'b0);
    run_cmd(i2cbm_pkg::KIND_ACK, 8'hFF, 1'b0, 1'b0);
    run_cmd(i2cbm_pkg::KIND_ACK, 8'h00, 1'b1, 1'b0);
    run_cmd(i2cbm_pkg::CMD_STOP, 8'h00, 1'b0, 1'b1);
    drain();

    // Long delay: a single start.
    cfg_write(16'd60);
    run_cmd(i2cbm_pkg::KIND_START, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
    drain();
    cfg_write(16'd1);

    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      if (words_sent > RANDOM_WORDS - 200) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end
      if (tx_gaps && $urandom_range(0, 3) == 0) begin
        drain();
        cfg_write(($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 3)));
      end
      if (!hold_request && words_sent > 300) begin
        hold_request = 1'b1;
      end
      if ($urandom_range(0, 5) == 0) begin
        // Broken sequence: any command on its own, then some idle ticks.
        run_cmd(3'($urandom_range(1, 6)), 8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
        nb = $urandom_range(0, 3);
        for (i = 0; i < nb; i++) begin
          push_word(i2cbm_pkg::KIND_TICK, 8'($urandom), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        end
      end else begin
        run_cmd(i2cbm_pkg::KIND_START, 8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
        nb = $urandom_range(1, 4);
        for (i = 0; i < nb; i++) begin
          if ($urandom_range(0, 1) == 0) begin
            run_cmd(i2cbm_pkg::KIND_WRITE, 8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
            run_cmd(i2cbm_pkg::KIND_WAITACK, 8'($urandom), 1'($urandom_range(0, 1)),
                    1'b1);
          end else begin
            run_cmd(i2cbm_pkg::KIND_READ, 8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
            run_cmd(i2cbm_pkg::KIND_ACK, 8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
          end
        end
        run_cmd(i2cbm_pkg::CMD_STOP, 8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("** i2c_bit_level_master: PASSED **");
    end else begin
      $display("** i2c_bit_level_master: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
src/i2cbm_pkg.sv
src/i2cbm_front.sv
src/i2cbm_engine.sv
src/i2c_bit_level_master.sv
tb/i2cbm_checker.sv
tb/testbench.sv
